### hw/rtl/sfcd_pkg.sv
`timescale 1ns / 1ps

package sfcd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned PERIOD_W  = 20;
	localparam int unsigned CHAN_W    = 3;
	localparam int unsigned SLOT_W    = 3;
	localparam int unsigned ACT_W     = 2;
	localparam int unsigned TDATA_W   = 96;
	localparam int unsigned OPS_N     = 4;

	localparam logic [BYTE_W-1:0] SYNC_HI = 8'hff;
	localparam logic [BYTE_W-1:0] SYNC_LO = 8'h55;

	localparam int unsigned LEN_POS   = 2;
	localparam int unsigned FIRST_POS = 3;
	localparam int unsigned LAST_POS  = 10;
	localparam int unsigned STORE_N   = LAST_POS - FIRST_POS + 1;
	localparam int unsigned STORE_AW  = $clog2(STORE_N);

	localparam logic [PERIOD_W-1:0] TONE_DIVIDEND = 20'd1000000;
	localparam logic [BYTE_W-1:0]   SERVO_MAX     = 8'd180;
	localparam logic [BYTE_W-1:0]   VALUE_FULL    = 8'd255;
	localparam logic [BYTE_W-1:0]   VALUE_ONE     = 8'd1;
	localparam logic [BYTE_W-1:0]   TRIG_RESET    = 8'd13;
	localparam logic [BYTE_W-1:0]   ECHO_RESET    = 8'd12;

	localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd0;
	localparam logic [ACT_W-1:0] ACT_GET     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SET     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESET   = 2'd3;

	localparam logic [BYTE_W-1:0] DEV_DIGITAL = 8'd1;
	localparam logic [BYTE_W-1:0] DEV_PWM     = 8'd3;
	localparam logic [BYTE_W-1:0] DEV_SERVO   = 8'd4;
	localparam logic [BYTE_W-1:0] DEV_TONE    = 8'd5;
	localparam logic [BYTE_W-1:0] DEV_ULTRA   = 8'd7;

	localparam logic [BYTE_W-1:0] PIN_PWM0 = 8'd3;
	localparam logic [BYTE_W-1:0] PIN_PWM1 = 8'd5;
	localparam logic [BYTE_W-1:0] PIN_PWM2 = 8'd6;
	localparam logic [BYTE_W-1:0] PIN_PWM3 = 8'd9;

	localparam logic [CHAN_W-1:0] CHAN_0    = 3'd0;
	localparam logic [CHAN_W-1:0] CHAN_1    = 3'd1;
	localparam logic [CHAN_W-1:0] CHAN_2    = 3'd2;
	localparam logic [CHAN_W-1:0] CHAN_3    = 3'd3;
	localparam logic [CHAN_W-1:0] CHAN_NONE = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] ms_hi;
		logic [BYTE_W-1:0] ms_lo;
		logic [BYTE_W-1:0] hz_hi;
		logic [BYTE_W-1:0] val;
		logic [BYTE_W-1:0] port;
		logic [BYTE_W-1:0] device;
		logic [BYTE_W-1:0] act_raw;
		logic [BYTE_W-1:0] cmd_index;
	} frame_t;

	// The first field sits in the highest bits.
	typedef struct packed {
		logic                     ultra_on;
		logic                     send_ok;
		logic [SLOT_W-1:0]        servo_slot;
		logic [CHAN_W-1:0]        pwm_channel;
		logic [PERIOD_W-1:0]      tone_period;
		logic signed [WORD_W-1:0] tone_ms;
		logic signed [WORD_W-1:0] tone_freq;
		logic [BYTE_W-1:0]        value;
		logic [BYTE_W-1:0]        port;
		logic [BYTE_W-1:0]        device;
		logic [ACT_W-1:0]         action;
		logic [BYTE_W-1:0]        cmd_index;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

### hw/rtl/sync_framed_command_decoder.sv
`timescale 1ns / 1ps

// Byte-stream command decoder. One received byte is taken per cycle while the decoder
// is idle; a byte that completes a frame starts a short decode sequence during which no
// byte is taken: a decide state, then either the restoring divider for a tone set, or a
// scan of the servo table at one entry per cycle (at most SERVO_SLOTS entries) for a
// servo set, then an output state that loads the output register once it is free. The
// command waits in the output register until the master side takes it.

module sync_framed_command_decoder import sfcd_pkg::*; #(
	parameter int unsigned FRAME_MAX   = 52,
	parameter int unsigned PIN_COUNT   = 14,
	parameter int unsigned SERVO_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,  // rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata   // cmd_index, action, device, port, value,
	                                     // tone_freq, tone_ms, tone_period,
	                                     // pwm_channel, servo_slot, send_ok, ultra_on
);

	localparam int unsigned SW = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SERVO = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]           state_q;
	logic                 m_tvalid_q;
	cmd_t                 out_q;
	logic                 ultra_q;
	logic [BYTE_W-1:0]    trig_q;
	logic [BYTE_W-1:0]    echo_q;
	logic [PIN_COUNT-1:0] pin_wr_q;
	logic [BYTE_W-1:0]    servo_q [SERVO_SLOTS];
	logic [SW-1:0]        scan_q;
	logic [SW-1:0]        slot_q;

	logic                 accept;
	logic                 frame_done;
	frame_t               fr;
	logic                 div_start;
	logic                 div_done;
	logic [PERIOD_W-1:0]  quotient;

	logic [ACT_W-1:0]     act;
	logic                 is_get;
	logic                 is_set;
	logic                 get_ultra;
	logic                 get_other;
	logic                 pair_diff;
	logic                 repin;
	logic                 set_mark;
	logic [WORD_W-1:0]    hz;
	logic [WORD_W-1:0]    ms;
	logic                 need_div;
	logic                 need_servo;
	logic [CHAN_W-1:0]    chan;
	logic [BYTE_W-1:0]    cur_entry;
	logic                 out_free;
	cmd_t                 cmd_next;
	logic [BYTE_W-1:0]    op_pin [OPS_N];
	logic                 op_val [OPS_N];
	logic                 op_en  [OPS_N];
	logic [PIN_COUNT-1:0] pin_next;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	sfcd_frame #(
		.FRAME_MAX(FRAME_MAX)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(s_tdata),
		.done   (frame_done),
		.frame  (fr)
	);

	sfcd_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (hz[WORD_W-2:0]),
		.done    (div_done),
		.quotient(quotient)
	);

	always_comb begin
		act        = (fr.act_raw[BYTE_W-1:ACT_W] == '0) ? fr.act_raw[ACT_W-1:0] : ACT_UNKNOWN;
		is_get     = (act == ACT_GET);
		is_set     = (act == ACT_SET);
		get_ultra  = is_get && (fr.device == DEV_ULTRA);
		get_other  = is_get && (fr.device != DEV_ULTRA);
		pair_diff  = (fr.port != trig_q) || (fr.val != echo_q);
		repin      = get_ultra && (!ultra_q || pair_diff);
		set_mark   = is_set && ((fr.device == DEV_DIGITAL) || (fr.device == DEV_PWM)
			|| (fr.device == DEV_SERVO) || (fr.device == DEV_TONE));
		hz         = {fr.hz_hi, fr.val};
		ms         = {fr.ms_hi, fr.ms_lo};
		need_div   = is_set && (fr.device == DEV_TONE) && !hz[WORD_W-1] && (hz != '0)
			&& !ms[WORD_W-1] && (ms != '0);
		need_servo = is_set && (fr.device == DEV_SERVO) && (fr.val <= SERVO_MAX);
		div_start  = (state_q == S_START) && need_div;
		cur_entry  = servo_q[scan_q];

		unique case (fr.port)
			PIN_PWM0: chan = CHAN_0;
			PIN_PWM1: chan = CHAN_1;
			PIN_PWM2: chan = CHAN_2;
			PIN_PWM3: chan = CHAN_3;
			default:  chan = CHAN_NONE;
		endcase

		cmd_next.cmd_index   = fr.cmd_index;
		cmd_next.action      = act;
		cmd_next.device      = fr.device;
		cmd_next.port        = fr.port;
		cmd_next.value       = (is_set && (fr.device == DEV_DIGITAL) && (fr.val == VALUE_FULL))
			? VALUE_ONE : fr.val;
		cmd_next.tone_freq   = hz;
		cmd_next.tone_ms     = ms;
		cmd_next.tone_period = need_div ? quotient : '0;
		cmd_next.pwm_channel = chan;
		cmd_next.servo_slot  = SLOT_W'(slot_q);
		cmd_next.send_ok     = is_set || (act == ACT_RESET);
		cmd_next.ultra_on    = is_get ? get_ultra : ultra_q;

		op_pin[0] = trig_q;
		op_val[0] = 1'b0;
		op_en[0]  = get_ultra && ultra_q && pair_diff;
		op_pin[1] = echo_q;
		op_val[1] = 1'b0;
		op_en[1]  = get_ultra && ultra_q && pair_diff;
		op_pin[2] = fr.port;
		op_val[2] = !get_other;
		op_en[2]  = repin || get_other || set_mark;
		op_pin[3] = fr.val;
		op_val[3] = 1'b1;
		op_en[3]  = repin;

		for (int p = 0; p < PIN_COUNT; p++) begin
			pin_next[p] = pin_wr_q[p];
			for (int k = 0; k < OPS_N; k++) begin
				if (op_en[k] && (op_pin[k] == BYTE_W'(p))) begin
					pin_next[p] = op_val[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			ultra_q    <= 1'b0;
			trig_q     <= TRIG_RESET;
			echo_q     <= ECHO_RESET;
			pin_wr_q   <= '0;
			scan_q     <= '0;
			slot_q     <= '0;
			for (int i = 0; i < SERVO_SLOTS; i++) begin
				servo_q[i] <= '0;
			end
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && frame_done) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					slot_q <= '0;
					scan_q <= '0;
					if (need_div) begin
						state_q <= S_DIV;
					end else if (need_servo) begin
						state_q <= S_SERVO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_SERVO: begin
					if (cur_entry == fr.port) begin
						slot_q  <= scan_q;
						state_q <= S_OUT;
					end else if (cur_entry == '0) begin
						servo_q[scan_q] <= fr.port;
						slot_q          <= scan_q;
						state_q         <= S_OUT;
					end else if (scan_q == SW'(SERVO_SLOTS - 1)) begin
						slot_q  <= '0;
						state_q <= S_OUT;
					end else begin
						scan_q <= scan_q + SW'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						ultra_q  <= cmd_next.ultra_on;
						pin_wr_q <= pin_next;
						if (repin) begin
							trig_q <= fr.port;
							echo_q <= fr.val;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_q <= cmd_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W - CMD_W){1'b0}}, out_q};

endmodule

### hw/rtl/sfcd_frame.sv
`timescale 1ns / 1ps

module sfcd_frame import sfcd_pkg::*; #(
	parameter int unsigned FRAME_MAX = 52
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              done,
	output frame_t            frame
);

	localparam int unsigned PW = $clog2(FRAME_MAX + 1);

	logic [BYTE_W-1:0] prev_q;
	logic              in_frame_q;
	logic [PW-1:0]     pos_q;
	logic [BYTE_W-1:0] rem_q;
	logic [BYTE_W-1:0] store_q [STORE_N];

	logic              sync;
	logic              open_frame;
	logic              inf_base;
	logic [PW-1:0]     pos_base;
	logic [PW-1:0]     pos_inc;
	logic              wrap;
	logic [BYTE_W-1:0] rem_next;
	logic              store_hit;

	always_comb begin
		sync       = (rx_byte == SYNC_LO) && !in_frame_q;
		open_frame = sync && (prev_q == SYNC_HI);
		pos_base   = open_frame ? PW'(1) : pos_q;
		inf_base   = open_frame || in_frame_q;
		rem_next   = rem_q;
		if (in_frame_q) begin
			if (pos_q == PW'(LEN_POS)) begin
				rem_next = rx_byte;
			end else if (pos_q > PW'(LEN_POS)) begin
				rem_next = rem_q - 8'd1;
			end
		end
		pos_inc   = pos_base + PW'(1);
		wrap      = pos_inc > PW'(FRAME_MAX - 1);
		done      = accept && inf_base && !wrap && (pos_inc > PW'(FIRST_POS))
			&& (rem_next == '0);
		store_hit = in_frame_q && (pos_q >= PW'(FIRST_POS)) && (pos_q <= PW'(LAST_POS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			if (!sync) begin
				prev_q <= rx_byte;
			end
			if (wrap || done) begin
				pos_q      <= '0;
				in_frame_q <= 1'b0;
			end else begin
				pos_q      <= pos_inc;
				in_frame_q <= inf_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_frame_q) begin
			rem_q <= rem_next;
		end
		if (accept && store_hit) begin
			store_q[STORE_AW'(pos_q - PW'(FIRST_POS))] <= rx_byte;
		end
	end

	assign frame.cmd_index = store_q[0];
	assign frame.act_raw   = store_q[1];
	assign frame.device    = store_q[2];
	assign frame.port      = store_q[3];
	assign frame.val       = store_q[4];
	assign frame.hz_hi     = store_q[5];
	assign frame.ms_lo     = store_q[6];
	assign frame.ms_hi     = store_q[7];

endmodule

### hw/rtl/sfcd_divider.sv
`timescale 1ns / 1ps

module sfcd_divider import sfcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WORD_W-2:0]   divisor,
	output logic                done,
	output logic [PERIOD_W-1:0] quotient
);

	localparam int unsigned CW = $clog2(PERIOD_W);
	localparam int unsigned RW = WORD_W - 1;

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     dvs_q;
	logic [PERIOD_W-1:0] quo_q;

	logic [RW:0]       shifted;
	logic              ge;
	logic [RW:0]       diff;

	always_comb begin
		shifted = {rem_q, quo_q[PERIOD_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
		done    = busy_q && (cnt_q == CW'(PERIOD_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= TONE_DIVIDEND;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RW-1:0] : shifted[RW-1:0];
			quo_q <= {quo_q[PERIOD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

### hw/rtl/sfcd_checker.sv
`timescale 1ns / 1ps

module sfcd_checker import sfcd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata
);

	cmd_t cmd;

	assign cmd = cmd_t'(m_tdata[CMD_W-1:0]);

	// A held result keeps its contents until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The acknowledge flag follows the action field.
	a_send_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cmd.send_ok == ((cmd.action == ACT_SET) || (cmd.action == ACT_RESET))))
		else $error("send_ok does not match action");

	// A tone period only comes with a tone set of positive frequency.
	a_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cmd.tone_period != '0) |->
			(cmd.action == ACT_SET) && (cmd.device == DEV_TONE) && !cmd.tone_freq[WORD_W-1])
		else $error("tone period without a tone set");

	// A new result is preceded by a cycle in which the input side was closed.
	a_decode_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a decode cycle");

endmodule

bind sync_framed_command_decoder sfcd_checker u_sfcd_checker (.*);

### sim/sync_framed_command_decoder_test.sv
`timescale 1ns / 1ps

module sync_framed_command_decoder_test;
	import sfcd_pkg::*;

	localparam int FRAME_LEN = 52;
	localparam int PINS      = 14;
	localparam int SERVOS    = 8;

	localparam logic [7:0] OP_NONE      = 8'(ACT_UNKNOWN);
	localparam logic [7:0] OP_GET       = 8'(ACT_GET);
	localparam logic [7:0] OP_SET       = 8'(ACT_SET);
	localparam logic [7:0] OP_RESET     = 8'(ACT_RESET);
	localparam logic [7:0] OP_UNDEFINED = 8'd4;
	localparam logic [7:0] DEV_UNUSED   = 8'd2;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;

	int src_gap_max;
	int sink_gap_max;
	int sink_hold;
	int mismatch_count;

	cmd_t pending_cmds[$];

	logic [7:0]      last_rx;
	bit              framing;
	int              frame_pos;
	logic [7:0]      len_left;
	logic [7:0]      frame_bytes[FRAME_LEN];
	logic [PINS-1:0] pin_marks;
	logic [7:0]      servo_entries[SERVOS];
	logic [7:0]      ultra_trig;
	logic [7:0]      ultra_echo;
	bit              ultra_active;

	sync_framed_command_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void reset_model();
		last_rx = '0;
		framing = 1'b0;
		frame_pos = 0;
		len_left = '0;
		foreach (frame_bytes[i]) frame_bytes[i] = '0;
		pin_marks = '0;
		foreach (servo_entries[i]) servo_entries[i] = '0;
		ultra_trig = TRIG_RESET;
		ultra_echo = ECHO_RESET;
		ultra_active = 1'b0;
	endfunction

	function automatic void mark_pin(input logic [7:0] pin, input logic v);
		if (pin < PINS) pin_marks[pin] = v;
	endfunction

	function automatic logic [SLOT_W-1:0] find_servo_slot(input logic [7:0] pin);
		for (int i = 0; i < SERVOS; i++) begin
			if (servo_entries[i] == pin) return SLOT_W'(i);
			if (servo_entries[i] == 8'd0) begin
				servo_entries[i] = pin;
				return SLOT_W'(i);
			end
		end
		return '0;
	endfunction

	function automatic cmd_t build_command();
		cmd_t c;
		logic [7:0] act_b, dev, port, val;
		logic signed [15:0] hz, ms;
		act_b = frame_bytes[4];
		dev = frame_bytes[5];
		port = frame_bytes[6];
		val = frame_bytes[7];
		hz = {frame_bytes[8], frame_bytes[7]};
		ms = {frame_bytes[10], frame_bytes[9]};
		c = '0;
		c.cmd_index = frame_bytes[3];
		c.device = dev;
		c.port = port;
		c.tone_freq = hz;
		c.tone_ms = ms;
		if (act_b == OP_GET || act_b == OP_SET || act_b == OP_RESET)
			c.action = act_b[ACT_W-1:0];
		else
			c.action = ACT_UNKNOWN;
		case (port)
			PIN_PWM0: c.pwm_channel = CHAN_0;
			PIN_PWM1: c.pwm_channel = CHAN_1;
			PIN_PWM2: c.pwm_channel = CHAN_2;
			PIN_PWM3: c.pwm_channel = CHAN_3;
			default:  c.pwm_channel = CHAN_NONE;
		endcase
		if (c.action == ACT_GET) begin
			if (dev == DEV_ULTRA) begin
				if (!ultra_active) begin
					ultra_active = 1'b1;
					ultra_trig = port;
					ultra_echo = val;
					mark_pin(port, 1'b1);
					mark_pin(val, 1'b1);
				end else if (port != ultra_trig || val != ultra_echo) begin
					mark_pin(ultra_trig, 1'b0);
					mark_pin(ultra_echo, 1'b0);
					ultra_trig = port;
					ultra_echo = val;
					mark_pin(port, 1'b1);
					mark_pin(val, 1'b1);
				end
			end else begin
				ultra_active = 1'b0;
				mark_pin(port, 1'b0);
			end
		end else if (c.action == ACT_SET) begin
			c.send_ok = 1'b1;
			if (dev == DEV_DIGITAL) begin
				mark_pin(port, 1'b1);
				if (val == VALUE_FULL) val = VALUE_ONE;
			end else if (dev == DEV_PWM) begin
				mark_pin(port, 1'b1);
			end else if (dev == DEV_TONE) begin
				mark_pin(port, 1'b1);
				if (hz > 0 && ms > 0) c.tone_period = TONE_DIVIDEND / PERIOD_W'(hz);
			end else if (dev == DEV_SERVO) begin
				mark_pin(port, 1'b1);
				if (val <= SERVO_MAX) c.servo_slot = find_servo_slot(port);
			end
		end else if (c.action == ACT_RESET) begin
			c.send_ok = 1'b1;
		end
		c.value = val;
		c.ultra_on = ultra_active;
		return c;
	endfunction

	function automatic bit take_rx_byte(input logic [7:0] b, output cmd_t c);
		c = '0;
		if (b == SYNC_LO && !framing) begin
			if (last_rx == SYNC_HI) begin
				frame_pos = 1;
				framing = 1'b1;
			end
		end else begin
			last_rx = b;
			if (framing) begin
				if (frame_pos == LEN_POS)
					len_left = b;
				else if (frame_pos > LEN_POS)
					len_left = len_left - 8'd1;
				if (frame_pos < FRAME_LEN) frame_bytes[frame_pos] = b;
			end
		end
		frame_pos++;
		if (frame_pos > FRAME_LEN - 1) begin
			frame_pos = 0;
			framing = 1'b0;
		end
		if (framing && frame_pos > FIRST_POS && len_left == 8'd0) begin
			framing = 1'b0;
			frame_pos = 0;
			c = build_command();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_rx_byte(input logic [7:0] b);
		int gap;
		cmd_t c;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		if (take_rx_byte(b, c)) pending_cmds.push_back(c);
	endtask

	task automatic send_frame(input logic [7:0] len, input logic [7:0] body[$]);
		send_rx_byte(SYNC_HI);
		send_rx_byte(SYNC_LO);
		send_rx_byte(len);
		foreach (body[i]) send_rx_byte(body[i]);
	endtask

	task automatic send_cmd_frame(input logic [7:0] idx, input logic [7:0] act_b,
			input logic [7:0] dev, input logic [7:0] port,
			input logic [15:0] hz, input logic [15:0] ms);
		logic [7:0] body[$];
		body = '{idx, act_b, dev, port, hz[7:0], hz[15:8], ms[7:0], ms[15:8]};
		send_frame(8'd8, body);
	endtask

	task automatic test_framing();
		logic [7:0] body[$];
		src_gap_max = 11;
		sink_gap_max = 11;
		send_rx_byte(SYNC_LO);
		send_rx_byte(SYNC_HI);
		send_rx_byte(8'h00);
		send_rx_byte(SYNC_LO);
		send_rx_byte(SYNC_LO);
		send_cmd_frame(8'h00, OP_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000);
		send_cmd_frame(8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff);
		// The frame above ends in 0xff, so a lone 0x55 opens the next one.
		body = '{8'h55, OP_SET, DEV_PWM, PIN_PWM3, 8'h55, SYNC_HI, SYNC_LO, SYNC_HI};
		send_rx_byte(SYNC_LO);
		send_rx_byte(8'd8);
		foreach (body[i]) send_rx_byte(body[i]);
		send_rx_byte(SYNC_HI);
		send_cmd_frame(8'h01, OP_SET, DEV_PWM, PIN_PWM1, 16'h0080, 16'h0000);
		send_rx_byte(SYNC_HI);
		send_rx_byte(8'h12);
		send_rx_byte(SYNC_LO);
		send_cmd_frame(8'h02, OP_SET, DEV_PWM, PIN_PWM2, 16'h0001, 16'h0000);
	endtask

	task automatic test_get_commands();
		src_gap_max = 0;
		sink_gap_max = 11;
		send_cmd_frame(8'h10, OP_GET, DEV_ULTRA, 8'd2, 16'h0004, 16'h0000);
		send_cmd_frame(8'h11, OP_GET, DEV_ULTRA, 8'd2, 16'h0004, 16'h0000);
		send_cmd_frame(8'h12, OP_GET, DEV_ULTRA, 8'd20, 16'h000b, 16'h0000);
		send_cmd_frame(8'h13, OP_GET, DEV_DIGITAL, PIN_PWM0, 16'h0000, 16'h0000);
		send_cmd_frame(8'h14, OP_GET, DEV_ULTRA, 8'd13, 16'h000c, 16'h0000);
		send_cmd_frame(8'h15, OP_GET, DEV_UNUSED, 8'd40, 16'h0000, 16'h0000);
	endtask

	task automatic test_set_commands();
		src_gap_max = 11;
		sink_gap_max = 0;
		send_cmd_frame(8'h20, OP_SET, DEV_DIGITAL, PIN_PWM0, 16'h00ff, 16'h0000);
		send_cmd_frame(8'h21, OP_SET, DEV_DIGITAL, 8'd40, 16'h00fe, 16'h0000);
		send_cmd_frame(8'h22, OP_SET, DEV_PWM, PIN_PWM1, 16'h0040, 16'h0000);
		send_cmd_frame(8'h23, OP_SET, DEV_UNUSED, PIN_PWM2, 16'h00ff, 16'h0000);
		send_cmd_frame(8'h24, OP_RESET, DEV_DIGITAL, PIN_PWM3, 16'h00ff, 16'h0000);
		send_cmd_frame(8'h25, OP_NONE, DEV_DIGITAL, 8'd7, 16'h00ff, 16'h0000);
		send_cmd_frame(8'h26, OP_UNDEFINED, DEV_TONE, 8'd8, 16'h01b8, 16'h0064);
	endtask

	task automatic test_tone_period();
		src_gap_max = 0;
		sink_gap_max = 0;
		send_cmd_frame(8'h30, OP_SET, DEV_TONE, PIN_PWM2, 16'h0001, 16'h0001);
		send_cmd_frame(8'h31, OP_SET, DEV_TONE, PIN_PWM2, 16'h7fff, 16'h7fff);
		send_cmd_frame(8'h32, OP_SET, DEV_TONE, PIN_PWM2, 16'h0000, 16'h0064);
		send_cmd_frame(8'h33, OP_SET, DEV_TONE, PIN_PWM2, 16'hffff, 16'h0064);
		send_cmd_frame(8'h34, OP_SET, DEV_TONE, PIN_PWM2, 16'h8000, 16'h0064);
		send_cmd_frame(8'h35, OP_SET, DEV_TONE, PIN_PWM2, 16'h01b8, 16'h0000);
		send_cmd_frame(8'h36, OP_SET, DEV_TONE, PIN_PWM2, 16'h01b8, 16'hfffb);
		send_cmd_frame(8'h37, OP_GET, DEV_TONE, PIN_PWM2, 16'h01b8, 16'h0064);
	endtask

	task automatic test_servo_table();
		src_gap_max = 11;
		sink_gap_max = 11;
		for (int p = 2; p <= 10; p++)
			send_cmd_frame(8'(p), OP_SET, DEV_SERVO, 8'(p), 16'h005a, 16'h0000);
		send_cmd_frame(8'h40, OP_SET, DEV_SERVO, 8'd3, 16'h005a, 16'h0000);
		send_cmd_frame(8'h41, OP_SET, DEV_SERVO, 8'd4, 16'h00b5, 16'h0000);
		send_cmd_frame(8'h42, OP_SET, DEV_SERVO, 8'd5, 16'h00b4, 16'h0000);
		send_cmd_frame(8'h43, OP_SET, DEV_SERVO, 8'd0, 16'h0000, 16'h0000);
	endtask

	task automatic test_frame_limits();
		logic [7:0] body[$];
		src_gap_max = 3;
		sink_gap_max = 3;
		body = '{8'h50, OP_SET, DEV_TONE, 8'd11, 8'h10, 8'h00, 8'h20, 8'h00};
		repeat (40) body.push_back(8'($urandom));
		send_frame(8'd48, body);
		body.delete();
		repeat (49) body.push_back(8'($urandom));
		send_frame(8'd49, body);
		send_frame(8'd0, body);
		body.delete();
		for (int n = 1; n <= 7; n += 2) begin
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
			send_frame(8'(n), body[0:n-1]);
		end
	endtask

	task automatic test_backpressure();
		src_gap_max = 0;
		sink_gap_max = 0;
		sink_hold = 400;
		repeat (3)
			send_cmd_frame(8'($urandom), OP_SET, DEV_TONE, 8'($urandom_range(0, 15)),
				16'($urandom_range(1, 32767)), 16'($urandom_range(1, 32767)));
	endtask

	task automatic send_random_frame();
		logic [7:0] body[$];
		logic [7:0] b;
		int len, n, r;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				r = $urandom_range(0, 3);
				b = (r == 0) ? SYNC_HI : (r == 1) ? SYNC_LO : 8'($urandom);
				send_rx_byte(b);
			end
		end
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(8, 12);
		else if (r < 82) len = $urandom_range(1, 7);
		else if (r < 92) len = $urandom_range(13, 48);
		else if (r < 96) len = 0;
		else len = $urandom_range(49, 255);
		n = (len == 0 || len > 48) ? 49 : len;
		for (int pos = 3; pos < n + 3; pos++) begin
			r = $urandom_range(0, 9);
			case (pos)
				4: b = (r < 8) ? 8'($urandom_range(1, 3)) : 8'($urandom);
				5: begin
					case ($urandom_range(0, 5))
						0: b = DEV_DIGITAL;
						1: b = DEV_PWM;
						2: b = DEV_SERVO;
						3: b = DEV_TONE;
						4: b = DEV_ULTRA;
						default: b = 8'($urandom);
					endcase
				end
				6: b = (r < 8) ? 8'($urandom_range(0, 15)) : 8'($urandom);
				7: b = (r == 0) ? VALUE_FULL : (r == 1) ? SERVO_MAX :
					(r == 2) ? SERVO_MAX + 8'd1 : (r == 3) ? 8'd0 : 8'($urandom);
				8: b = (r < 4) ? 8'd0 : 8'($urandom);
				10: b = (r < 2) ? 8'd0 : (r < 4) ? 8'h80 : 8'($urandom);
				default: b = 8'($urandom);
			endcase
			body.push_back(b);
		end
		send_frame(8'(len), body);
	endtask

	task automatic test_random_traffic();
		repeat (2) begin
			case ($urandom_range(0, 3))
				0: begin src_gap_max = 0; sink_gap_max = 0; end
				1: begin src_gap_max = 11; sink_gap_max = 0; end
				2: begin src_gap_max = 0; sink_gap_max = 11; end
				default: begin src_gap_max = 11; sink_gap_max = 11; end
			endcase
			repeat (2) send_random_frame();
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_cmds
		cmd_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = cmd_t'(m_tdata[CMD_W-1:0]);
			if (pending_cmds.size() == 0) begin
				$display("%0t: command expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_cmds.pop_front();
				check_field("cmd_index", 32'(want.cmd_index), 32'(got.cmd_index));
				check_field("action", 32'(want.action), 32'(got.action));
				check_field("device", 32'(want.device), 32'(got.device));
				check_field("port", 32'(want.port), 32'(got.port));
				check_field("value", 32'(want.value), 32'(got.value));
				check_field("tone_freq", 32'(want.tone_freq), 32'(got.tone_freq));
				check_field("tone_ms", 32'(want.tone_ms), 32'(got.tone_ms));
				check_field("tone_period", 32'(want.tone_period), 32'(got.tone_period));
				check_field("pwm_channel", 32'(want.pwm_channel), 32'(got.pwm_channel));
				check_field("servo_slot", 32'(want.servo_slot), 32'(got.servo_slot));
				check_field("send_ok", 32'(want.send_ok), 32'(got.send_ok));
				check_field("ultra_on", 32'(want.ultra_on), 32'(got.ultra_on));
				check_field("padding", 32'd0, 32'(m_tdata[TDATA_W-1:CMD_W]));
			end
		end
	end

	// The receiver draws a wait after every transfer; a requested hold takes precedence.
	initial begin : sink_side
		int wait_left;
		wait_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (wait_left > 0) begin
				m_tready <= 1'b0;
				wait_left--;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) wait_left = $urandom_range(0, sink_gap_max);
		end
	end

	initial begin
		#2_000_000;
		$display("[sync_framed_command_decoder] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_gap_max = 0;
		sink_gap_max = 0;
		sink_hold = 0;
		mismatch_count = 0;
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_framing();
		test_get_commands();
		test_set_commands();
		test_tone_period();
		test_servo_table();
		test_frame_limits();
		test_backpressure();
		test_random_traffic();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[sync_framed_command_decoder] OK");
		end else begin
			$display("[sync_framed_command_decoder] ERROR");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/sfcd_pkg.sv
hw/rtl/sfcd_frame.sv
hw/rtl/sfcd_divider.sv
hw/rtl/sync_framed_command_decoder.sv
hw/rtl/sfcd_checker.sv
sim/sync_framed_command_decoder_test.sv
